@@ hw/rtl/tms_pkg.sv @@
// ----------------------------------------------------------------------------
// tms_pkg
// Shared widths, register indexes and controller/datapath interface types
// for the trimmed mean scorer.
// ----------------------------------------------------------------------------
package tms_pkg;

  localparam int MAX_JUDGES = 64;
  localparam int MIN_JUDGES = 3;
  localparam int MARK_W     = 16;
  localparam int JC_W       = 7;
  localparam int CNT_W      = $clog2(MAX_JUDGES + 1);
  localparam int SUM_W      = MARK_W + $clog2(MAX_JUDGES);
  // The divider retires two quotient bits per cycle.
  localparam int DIV_CYC    = (SUM_W + 1) / 2;
  localparam int QUO_W      = 2 * DIV_CYC;
  localparam int STEP_W     = $clog2(DIV_CYC);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_JUDGE_COUNT    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PASS_THRESHOLD = CFG_IDX_W'(1);

  typedef struct packed {
    logic accept;
    logic start;
    logic div_step;
    logic load_trim;
    logic load_out;
  } tms_cmd_t;

  typedef struct packed {
    logic set_end;
  } tms_stat_t;

endpackage

@@ hw/rtl/tms_datapath.sv @@
// ----------------------------------------------------------------------------
// tms_datapath
// Configuration registers, set accumulators, a shared radix-4 restoring
// divider and the result register.
// ----------------------------------------------------------------------------
module tms_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [tms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tms_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [tms_pkg::MARK_W-1:0]     mark,
  input  tms_pkg::tms_cmd_t              cmd,
  output tms_pkg::tms_stat_t             stat,
  output logic [tms_pkg::MARK_W-1:0]     trimmed_mean,
  output logic [tms_pkg::MARK_W-1:0]     full_mean,
  output logic [tms_pkg::MARK_W-1:0]     dropped_low,
  output logic [tms_pkg::MARK_W-1:0]     dropped_high,
  output logic                           passed
);
  import tms_pkg::*;

  logic [JC_W-1:0]   judge_count;
  logic [MARK_W-1:0] pass_threshold;

  logic [CNT_W-1:0]  marks_seen;
  logic [SUM_W-1:0]  running_sum;
  logic [MARK_W-1:0] lowest_so_far;
  logic [MARK_W-1:0] highest_so_far;

  logic [CNT_W-1:0]  seen_next;
  logic [SUM_W-1:0]  sum_next;
  logic [MARK_W-1:0] low_next;
  logic [MARK_W-1:0] high_next;
  logic [CNT_W-1:0]  eff_count;

  // Operands of the set under division
  logic [SUM_W-1:0]  op_sum;
  logic [MARK_W-1:0] op_low;
  logic [MARK_W-1:0] op_high;
  logic [CNT_W-1:0]  op_n;

  logic [CNT_W-1:0]  rem;
  logic [QUO_W-1:0]  quo;
  logic [CNT_W-1:0]  divisor;
  logic [MARK_W-1:0] full_q;
  logic [CNT_W+QUO_W-1:0] stepped;
  logic [SUM_W-1:0]  trim_sum;

  function automatic logic [CNT_W+QUO_W-1:0] div_step2(
    input logic [CNT_W-1:0] r,
    input logic [QUO_W-1:0] q,
    input logic [CNT_W-1:0] d
  );
    logic [CNT_W:0]   t;
    logic [CNT_W-1:0] rr;
    logic [QUO_W-1:0] qq;
    rr = r;
    qq = q;
    for (int k = 0; k < 2; k++) begin
      t  = {rr, qq[QUO_W-1]};
      qq = {qq[QUO_W-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
        t     = t - {1'b0, d};
        qq[0] = 1'b1;
      end
      rr = t[CNT_W-1:0];
    end
    return {rr, qq};
  endfunction

  always_comb begin
    if (judge_count < JC_W'(MIN_JUDGES)) begin
      eff_count = CNT_W'(MIN_JUDGES);
    end else if (judge_count > JC_W'(MAX_JUDGES)) begin
      eff_count = CNT_W'(MAX_JUDGES);
    end else begin
      eff_count = CNT_W'(judge_count);
    end
  end

  assign seen_next = marks_seen + CNT_W'(1);
  assign sum_next  = running_sum + SUM_W'(mark);
  assign low_next  = (mark < lowest_so_far) ? mark : lowest_so_far;
  assign high_next = (mark > highest_so_far) ? mark : highest_so_far;
  assign stat.set_end = (seen_next >= eff_count);

  assign stepped  = div_step2(rem, quo, divisor);
  assign trim_sum = op_sum - SUM_W'(op_low) - SUM_W'(op_high);

  always_ff @(posedge clk) begin
    if (rst) begin
      judge_count    <= JC_W'(MIN_JUDGES);
      pass_threshold <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_JUDGE_COUNT:    judge_count    <= cfg_data[JC_W-1:0];
        REG_PASS_THRESHOLD: pass_threshold <= cfg_data[MARK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.start) begin
      marks_seen     <= '0;
      running_sum    <= '0;
      lowest_so_far  <= '1;
      highest_so_far <= '0;
    end else if (cmd.accept) begin
      marks_seen     <= seen_next;
      running_sum    <= sum_next;
      lowest_so_far  <= low_next;
      highest_so_far <= high_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_sum  <= sum_next;
      op_low  <= low_next;
      op_high <= high_next;
      op_n    <= seen_next;
      rem     <= '0;
      quo     <= QUO_W'(sum_next);
      divisor <= seen_next;
    end else if (cmd.load_trim) begin
      // The final step of the full mean lands here while the trimmed
      // division is loaded.
      full_q  <= stepped[MARK_W-1:0];
      rem     <= '0;
      quo     <= QUO_W'(trim_sum);
      divisor <= op_n - CNT_W'(2);
    end else if (cmd.div_step) begin
      rem <= stepped[CNT_W+QUO_W-1:QUO_W];
      quo <= stepped[QUO_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      trimmed_mean <= quo[MARK_W-1:0];
      full_mean    <= full_q;
      dropped_low  <= op_low;
      dropped_high <= op_high;
      passed       <= (full_q >= pass_threshold);
    end
  end

endmodule

@@ hw/rtl/tms_controller.sv @@
// ----------------------------------------------------------------------------
// tms_controller
// Handshake control, divider sequencing and output valid for the scorer.
// ----------------------------------------------------------------------------
module tms_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  tms_pkg::tms_stat_t stat,
  output tms_pkg::tms_cmd_t  cmd
);
  import tms_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FULL = 2'd1;
  localparam logic [1:0] S_TRIM = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [STEP_W-1:0] step;
  logic              last_step;
  logic              accept;
  logic              start;
  logic              div_step;
  logic              load_trim;
  logic              load_out;

  assign last_step = (step == STEP_W'(DIV_CYC - 1));

  // Marks that do not close a set are taken at any time; a closing mark
  // waits until the controller is back in idle.
  assign in_ready = !stat.set_end || (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign start    = accept && stat.set_end;

  assign cmd.accept    = accept;
  assign cmd.start     = start;
  assign cmd.div_step  = div_step;
  assign cmd.load_trim = load_trim;
  assign cmd.load_out  = load_out;

  always_comb begin
    state_next = state;
    div_step   = 1'b0;
    load_trim  = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_FULL;
      end
      S_FULL: begin
        if (last_step) begin
          load_trim  = 1'b1;
          state_next = S_TRIM;
        end else begin
          div_step = 1'b1;
        end
      end
      S_TRIM: begin
        div_step = 1'b1;
        if (last_step) state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == S_FULL || state == S_TRIM) && !last_step) begin
        step <= step + STEP_W'(1);
      end else begin
        step <= '0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/trimmed_mean_scorer.sv @@
// ----------------------------------------------------------------------------
// trimmed_mean_scorer
// Scores sets of judges' marks: trimmed mean, plain mean, dropped marks and
// a pass flag.
//
// Marks enter on the in_valid/in_ready channel, one per transaction, and
// sets of judge_count marks (clamped to 3..64) close on their last mark.
// Each closed set yields one result transaction on out_valid/out_ready.
// Registers are written through cfg_write, cfg_index and cfg_data; the user
// must do so only while the block is idle, as the block itself does not
// enforce it. Index 0 is judge_count, index 1 is the pass threshold. Marks
// that do not close a set are taken in one cycle each, also while the
// previous set is still being divided. The closing mark is accepted only
// when the shared divider is free; it then needs two divisions, the full
// mean first and the trimmed mean second, before its result is registered.
// The result is held in an output register; if the receiver stalls, the
// next set still accumulates, and only its closing mark waits.
// Reset clears the set in progress and restores judge_count to 3 and the
// pass threshold to 0.
// ----------------------------------------------------------------------------
module trimmed_mean_scorer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [tms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tms_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [tms_pkg::MARK_W-1:0]     mark,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tms_pkg::MARK_W-1:0]     trimmed_mean,
  output logic [tms_pkg::MARK_W-1:0]     full_mean,
  output logic [tms_pkg::MARK_W-1:0]     dropped_low,
  output logic [tms_pkg::MARK_W-1:0]     dropped_high,
  output logic                           passed
);
  import tms_pkg::*;

  tms_cmd_t  cmd;
  tms_stat_t stat;

  tms_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tms_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mark         (mark),
    .cmd          (cmd),
    .stat         (stat),
    .trimmed_mean (trimmed_mean),
    .full_mean    (full_mean),
    .dropped_low  (dropped_low),
    .dropped_high (dropped_high),
    .passed       (passed)
  );

endmodule

@@ hw/rtl/tms_checker.sv @@
// ----------------------------------------------------------------------------
// tms_checker
// Port-level checks on the scorer's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module tms_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [tms_pkg::MARK_W-1:0] trimmed_mean,
  input logic [tms_pkg::MARK_W-1:0] full_mean,
  input logic [tms_pkg::MARK_W-1:0] dropped_low,
  input logic [tms_pkg::MARK_W-1:0] dropped_high
);
  import tms_pkg::*;

  // A stalled result transaction stays valid and keeps both means.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(trimmed_mean) && $stable(full_mean))
    else $error("result changed while stalled");

  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> dropped_low <= dropped_high)
    else $error("dropped low above dropped high");

  // Both means are averages of marks lying between the two dropped marks.
  a_trim_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> trimmed_mean >= dropped_low && trimmed_mean <= dropped_high)
    else $error("trimmed mean outside dropped marks");

  a_full_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> full_mean >= dropped_low && full_mean <= dropped_high)
    else $error("full mean outside dropped marks");

endmodule

bind trimmed_mean_scorer tms_checker u_tms_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .trimmed_mean (trimmed_mean),
  .full_mean    (full_mean),
  .dropped_low  (dropped_low),
  .dropped_high (dropped_high)
);

@@ tb/tb_trimmed_mean_scorer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trimmed_mean_scorer
// Self-checking testbench for the trimmed mean scorer. Marks are sent on the
// input channel while a behavioural scorer in the bench works out each set's
// result. Every result transaction is compared with the oldest prediction.
// Directed sets cover the extremes, equal marks, the pass threshold,
// clamping of the set size, spare register indexes and a size change while a
// set is open. Long random runs then sweep settings and mark patterns under
// varying back-pressure.
// ----------------------------------------------------------------------------
module tb_trimmed_mean_scorer;
  import tms_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);
  localparam int DRAIN_CYCLES = 32;
  localparam int STALL_LIMIT  = 3000;
  localparam int PHASE_MARKS  = 430;

  typedef struct packed {
    logic [MARK_W-1:0] trimmed;
    logic [MARK_W-1:0] full;
    logic [MARK_W-1:0] low;
    logic [MARK_W-1:0] high;
    logic              passed;
  } score_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [MARK_W-1:0]     mark = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [MARK_W-1:0]     trimmed_mean;
  logic [MARK_W-1:0]     full_mean;
  logic [MARK_W-1:0]     dropped_low;
  logic [MARK_W-1:0]     dropped_high;
  logic                  passed;

  // Scorer state mirrored in the bench.
  logic [JC_W-1:0]   judge_count_reg = JC_W'(MIN_JUDGES);
  logic [MARK_W-1:0] passing_reg = '0;
  logic [JC_W-1:0]   set_count = '0;
  logic [SUM_W-1:0]  set_sum = '0;
  logic [MARK_W-1:0] set_low = '1;
  logic [MARK_W-1:0] set_high = '0;

  score_t pending_scores[$];
  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  int fail_count = 0;
  int marks_sent = 0;
  int scores_checked = 0;
  int reg_writes = 0;
  int smallest_set = 127;
  int largest_set = 0;
  int stall_cycles = 0;

  trimmed_mean_scorer dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mark(mark),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .trimmed_mean(trimmed_mean),
    .full_mean(full_mean),
    .dropped_low(dropped_low),
    .dropped_high(dropped_high),
    .passed(passed)
  );

  always #2 clk = ~clk;

  // Adds one mark to the open set; returns 1 with the score when it closes.
  function automatic bit score_mark(input logic [MARK_W-1:0] m, output score_t s);
    int unsigned limit;
    int unsigned n;
    int unsigned sum_v;
    int unsigned full_v;
    set_sum = set_sum + SUM_W'(m);
    if (m < set_low) set_low = m;
    if (m > set_high) set_high = m;
    set_count = set_count + 1'b1;
    limit = judge_count_reg;
    if (limit < MIN_JUDGES) limit = MIN_JUDGES;
    if (limit > MAX_JUDGES) limit = MAX_JUDGES;
    s = '0;
    if (set_count < limit) return 1'b0;
    n = set_count;
    sum_v = set_sum;
    full_v = sum_v / n;
    s.full = MARK_W'(full_v);
    s.trimmed = MARK_W'((sum_v - set_low - set_high) / (n - 2));
    s.low = set_low;
    s.high = set_high;
    s.passed = (full_v >= passing_reg);
    if (n < smallest_set) smallest_set = n;
    if (n > largest_set) largest_set = n;
    set_count = '0;
    set_sum = '0;
    set_low = '1;
    set_high = '0;
    return 1'b1;
  endfunction

  function automatic logic [MARK_W-1:0] clamp_mark(input int v);
    if (v < 0) return '0;
    if (v > 65535) return '1;
    return MARK_W'(v);
  endfunction

  task automatic send_mark(input logic [MARK_W-1:0] m);
    int gap;
    score_t s;
    gap = 0;
    while ($urandom_range(0, 99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mark <= m;
    do @(posedge clk); while (!in_ready);
    marks_sent++;
    if (score_mark(m, s)) pending_scores.push_back(s);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_JUDGE_COUNT: judge_count_reg = data[JC_W-1:0];
      REG_PASS_THRESHOLD: passing_reg = data;
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  // Holds off the sender until every result is in and the divider has settled.
  task automatic wait_idle;
    in_valid <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_defaults;
    send_mark(16'd0); send_mark(16'd0); send_mark(16'd0);
    send_mark(16'hFFFF); send_mark(16'hFFFF); send_mark(16'hFFFF);
    send_mark(16'd0); send_mark(16'hFFFF); send_mark(16'd1234);
  endtask

  task automatic test_pass_threshold;
    wait_idle();
    write_reg(REG_PASS_THRESHOLD, 16'hFFFF);
    // Upper data bits are not part of the set size; zero is clamped to three.
    write_reg(REG_JUDGE_COUNT, 16'hFF80);
    send_mark(16'hFFFF); send_mark(16'hFFFF); send_mark(16'hFFFE);
    send_mark(16'hFFFF); send_mark(16'hFFFF); send_mark(16'hFFFF);
    wait_idle();
    write_reg(REG_PASS_THRESHOLD, 16'd100);
    send_mark(16'd100); send_mark(16'd101); send_mark(16'd99);
    send_mark(16'd99); send_mark(16'd100); send_mark(16'd100);
  endtask

  task automatic test_spare_index;
    wait_idle();
    write_reg(REG_SPARE_A, 16'hFFFF);
    write_reg(REG_SPARE_B, 16'hFFFF);
    send_mark(16'd1); send_mark(16'd2); send_mark(16'd4);
  endtask

  task automatic test_size_change_open_set;
    wait_idle();
    write_reg(REG_JUDGE_COUNT, 16'd10);
    repeat (5) send_mark(MARK_W'($urandom_range(0, 65535)));
    wait_idle();
    // The open set already holds more marks than the new size allows.
    write_reg(REG_JUDGE_COUNT, 16'd4);
    write_reg(REG_PASS_THRESHOLD, 16'd30000);
    send_mark(MARK_W'($urandom_range(0, 65535)));
  endtask

  task automatic test_set_size_limits;
    wait_idle();
    write_reg(REG_JUDGE_COUNT, 16'd2);
    repeat (3) send_mark(MARK_W'($urandom_range(0, 65535)));
    wait_idle();
    write_reg(REG_JUDGE_COUNT, 16'd64);
    repeat (64) send_mark(MARK_W'($urandom_range(0, 65535)));
    wait_idle();
    write_reg(REG_JUDGE_COUNT, 16'h007F);
    repeat (64) send_mark(MARK_W'($urandom_range(0, 65535)));
  endtask

  task automatic test_random_phase(input int send_pct, input int recv_pct, input int quota);
    int start_count;
    int r;
    int limit;
    int sets;
    int extra;
    int style;
    int centre;
    int spread;
    logic [JC_W-1:0] jc;
    logic [MARK_W-1:0] m;
    sender_idle_pct = send_pct;
    receiver_idle_pct = recv_pct;
    start_count = marks_sent;
    while (marks_sent - start_count < quota) begin
      wait_idle();
      r = $urandom_range(0, 99);
      if (r < 65) jc = JC_W'($urandom_range(3, 8));
      else if (r < 75) jc = JC_W'($urandom_range(0, 2));
      else if (r < 87) jc = JC_W'($urandom_range(9, 24));
      else if (r < 94) jc = JC_W'($urandom_range(60, 64));
      else jc = JC_W'($urandom_range(65, 127));
      write_reg(REG_JUDGE_COUNT, {9'($urandom_range(0, 511)), jc});
      centre = $urandom_range(0, 65535);
      spread = $urandom_range(0, 200);
      r = $urandom_range(0, 99);
      if (r < 50) write_reg(REG_PASS_THRESHOLD, clamp_mark(centre + $urandom_range(0, 60) - 30));
      else if (r < 70) write_reg(REG_PASS_THRESHOLD, CFG_DATA_W'($urandom_range(0, 65535)));
      else if (r < 85) write_reg(REG_PASS_THRESHOLD, '0);
      else write_reg(REG_PASS_THRESHOLD, '1);
      if ($urandom_range(0, 9) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                  CFG_DATA_W'($urandom_range(0, 65535)));
      limit = (jc < MIN_JUDGES) ? MIN_JUDGES : (jc > MAX_JUDGES) ? MAX_JUDGES : jc;
      sets = (limit > 24) ? $urandom_range(1, 2) : $urandom_range(3, 12);
      // Now and then a set is left open across the next register change.
      extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, limit - 1) : 0;
      style = $urandom_range(0, 3);
      repeat (sets * limit + extra) begin
        case (style)
          0: m = MARK_W'($urandom_range(0, 65535));
          1: m = clamp_mark(centre + $urandom_range(0, 2 * spread) - spread);
          2: m = MARK_W'(centre);
          default: m = $urandom_range(0, 1) ? MARK_W'($urandom_range(65500, 65535))
                                             : MARK_W'($urandom_range(0, 35));
        endcase
        send_mark(m);
      end
    end
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
  end

  always @(posedge clk) begin : check_scores
    score_t got;
    score_t want;
    if (!rst && out_valid && out_ready) begin
      got.trimmed = trimmed_mean;
      got.full = full_mean;
      got.low = dropped_low;
      got.high = dropped_high;
      got.passed = passed;
      scores_checked++;
      if (pending_scores.size() == 0) begin
        if (fail_count < 10)
          $display("Unexpected result: trimmed %0d full %0d low %0d high %0d passed %0d",
                   got.trimmed, got.full, got.low, got.high, got.passed);
        fail_count++;
      end else begin
        want = pending_scores.pop_front();
        if (got !== want) begin
          if (fail_count < 10) begin
            $display("Mismatch on result %0d:", scores_checked);
            $display("  expected trimmed %0d full %0d low %0d high %0d passed %0d",
                     want.trimmed, want.full, want.low, want.high, want.passed);
            $display("  actual   trimmed %0d full %0d low %0d high %0d passed %0d",
                     got.trimmed, got.full, got.low, got.high, got.passed);
          end
          fail_count++;
        end
      end
    end
  end

  // Ends the run if no transaction moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    sender_idle_pct = 10;
    receiver_idle_pct = 62;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_pass_threshold();
    test_spare_index();
    test_size_change_open_set();
    test_set_size_limits();
    test_random_phase(10, 62, PHASE_MARKS);
    test_random_phase(62, 10, PHASE_MARKS);
    test_random_phase(0, 0, PHASE_MARKS);
    wait_idle();
    fail_count += pending_scores.size();
    $display("Sent %0d marks and checked %0d scored sets of %0d to %0d marks.",
             marks_sent, scores_checked, smallest_set, largest_set);
    $display("Made %0d register writes, including spare indexes and clamped set sizes.",
             reg_writes);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
